// ===== rtl/core/forest_majority_vote_classifier_top_macros.svh =====
// Assertion macros for the forest classifier.
// No dependencies; bodies vanish under SYNTHESIS.
`ifndef FOREST_MAJORITY_VOTE_CLASSIFIER_TOP_MACROS_SVH
`define FOREST_MAJORITY_VOTE_CLASSIFIER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FMV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FMV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FMV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FMV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/fmv_pkg.sv =====
// Types and codes shared by the forest classifier.
// No dependencies.
package fmv_pkg;
    localparam int NODE_COUNT    = 1024;
    localparam int SPLIT_COUNT   = 1024;
    localparam int TREE_COUNT    = 64;
    localparam int CLASS_COUNT   = 8;
    localparam int FEATURE_COUNT = 21;
    localparam int DEPTH_LIMIT   = 32;

    typedef enum logic [2:0] {
        FUNC_NODE     = 3'd0,
        FUNC_SPLIT    = 3'd1,
        FUNC_ROOT     = 3'd2,
        FUNC_FEATURE  = 3'd3,
        FUNC_CLASSIFY = 3'd4
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_NODE,
        ST_NODE_WAIT,
        ST_SPLIT_WAIT,
        ST_FEAT_WAIT,
        ST_DECIDE,
        ST_VOTE,
        ST_NEXT,
        ST_DONE
    } t_state;

    localparam logic CFG_TREE_COUNT  = 1'b0;
    localparam logic CFG_CLASS_COUNT = 1'b1;

    // IEEE single a <= b; false when either is NaN
    function automatic logic fp_le(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic a_zero;
        logic b_zero;
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (a_nan || b_nan) begin
            fp_le = 1'b0;
        end else if (a_zero && b_zero) begin
            fp_le = 1'b1;
        end else if (a[31] != b[31]) begin
            fp_le = a[31];
        end else if (a[31]) begin
            fp_le = (a[30:0] >= b[30:0]);
        end else begin
            fp_le = (a[30:0] <= b[30:0]);
        end
    endfunction
endpackage

// ===== rtl/core/forest_majority_vote_classifier_top.sv =====
// Forest classifier top: tables, tree-walk sequencer, vote counters.
// Depends on fmv_pkg and forest_majority_vote_classifier_top_macros.svh.
//
// channel  | handshake          | payload
// command  | i_start / o_busy   | i_func .. i_inversed
// config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// result   | o_result_valid     | o_predicted_value, o_winning_votes, o_walk_error
//
// Table writes are registered on acceptance. Classify: a counter clear per
// class, then per tree a root read and per level node, split and feature
// memory reads in series (split and feature only for split nodes), plus a
// vote step per leaf.
// Reset is synchronous; results are strobed one cycle, no stall.
`include "forest_majority_vote_classifier_top_macros.svh"
module forest_majority_vote_classifier_top
    import fmv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_func,
    input  logic [9:0]         i_index,
    input  logic signed [10:0] i_left_link,
    input  logic [9:0]         i_right_link,
    input  logic signed [10:0] i_chain_link,
    input  logic signed [1:0]  i_default_dir,
    input  logic [2:0]         i_class_index,
    input  logic [7:0]         i_node_value,
    input  logic [4:0]         i_feature_select,
    input  logic [31:0]        i_word,
    input  logic               i_inversed,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [6:0]         i_cfg_data,
    output logic               o_result_valid,
    output logic [7:0]         o_predicted_value,
    output logic [6:0]         o_winning_votes,
    output logic               o_walk_error
);
    localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int SW = (SPLIT_COUNT > 1) ? $clog2(SPLIT_COUNT) : 1;
    localparam int TW = (TREE_COUNT > 1) ? $clog2(TREE_COUNT) : 1;
    localparam int CW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int DW = $clog2(DEPTH_LIMIT + 1);
    localparam int TCW = $clog2(TREE_COUNT + 1);
    localparam int CCW = $clog2(CLASS_COUNT + 1);

    // node word: left(11) right(10) chain(11) dflt(2) cls(3) val(8)
    logic [44:0] node_mem [NODE_COUNT];
    logic [37:0] split_mem [SPLIT_COUNT];
    logic [10:0] root_mem [TREE_COUNT];
    logic [31:0] feat_mem [FEATURE_COUNT];
    logic [6:0]  r_votes [CLASS_COUNT];

    logic [44:0] r_node_q;
    logic [37:0] r_split_q;
    logic [10:0] r_root_q;
    logic [31:0] r_feat_q;

    t_state r_state, n_state;
    logic [6:0] r_tree_cfg;
    logic [3:0] r_class_cfg;
    logic [TCW-1:0] r_tree, r_ntrees;
    logic [CCW-1:0] r_ncls;
    logic [CW-1:0] r_clr;
    logic signed [10:0] r_cur;
    logic [DW-1:0] r_moves;
    logic [7:0] r_pv;
    logic [6:0] r_best;
    logic r_err;

    logic accept;
    logic cmd_idle;
    assign cmd_idle = (r_state == ST_IDLE);
    assign o_busy = !cmd_idle;
    assign o_cfg_ready = cmd_idle;
    assign accept = i_start && cmd_idle;

    // decoded node fields
    logic signed [10:0] nd_left, nd_chain;
    logic [9:0] nd_right;
    logic signed [1:0] nd_dflt;
    logic [2:0] nd_cls;
    logic [7:0] nd_val;
    assign nd_left  = r_node_q[44:34];
    assign nd_right = r_node_q[33:24];
    assign nd_chain = r_node_q[23:13];
    assign nd_dflt  = r_node_q[12:11];
    assign nd_cls   = r_node_q[10:8];
    assign nd_val   = r_node_q[7:0];

    logic cur_ok, is_leaf, has_split, feat_ok, go_left, cls_ok;
    logic [4:0] sp_feat;
    logic [31:0] feat_val;
    assign sp_feat = r_split_q[37:33];
    assign cur_ok = (r_cur >= 0) && (32'(r_cur) < NODE_COUNT);
    assign is_leaf = (nd_left == -11'sd1);
    assign has_split = (nd_chain >= 0) && (32'(nd_chain) < SPLIT_COUNT);
    assign feat_ok = (32'(sp_feat) < FEATURE_COUNT);
    assign feat_val = feat_ok ? r_feat_q : 32'd0;
    assign cls_ok = ({1'b0, nd_cls} < 4'(r_ncls));
    always_comb begin
        if (!has_split) begin
            go_left = nd_dflt[1];
        end else begin
            go_left = fp_le(feat_val, r_split_q[31:0]) ^ r_split_q[32];
        end
    end

    // table writes and reads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            unique case (i_func)
                FUNC_NODE: if (32'(i_index) < NODE_COUNT)
                    node_mem[i_index[NW-1:0]] <= {i_left_link, i_right_link, i_chain_link,
                                                 i_default_dir, i_class_index, i_node_value};
                FUNC_SPLIT: if (32'(i_index) < SPLIT_COUNT)
                    split_mem[i_index[SW-1:0]] <= {i_feature_select, i_inversed, i_word};
                FUNC_ROOT: if (32'(i_index) < TREE_COUNT)
                    root_mem[i_index[TW-1:0]] <= i_left_link;
                FUNC_FEATURE: if (32'(i_index) < FEATURE_COUNT)
                    feat_mem[i_index[FW-1:0]] <= i_word;
                default: ;
            endcase
        end
        r_root_q  <= root_mem[r_tree[TW-1:0]];
        r_node_q  <= node_mem[r_cur[NW-1:0]];
        r_split_q <= split_mem[nd_chain[SW-1:0]];
        r_feat_q  <= feat_mem[sp_feat[FW-1:0]];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:       if (accept && i_func == FUNC_CLASSIFY) n_state = ST_CLEAR;
            ST_CLEAR:      if (32'(r_clr) == CLASS_COUNT - 1) n_state = ST_NEXT;
            ST_ROOT:       n_state = ST_ROOT_WAIT;
            ST_ROOT_WAIT:  n_state = ST_NODE;
            ST_NODE:       n_state = cur_ok ? ST_NODE_WAIT : ST_NEXT;
            ST_NODE_WAIT:  begin
                if (is_leaf) n_state = ST_VOTE;
                else if (32'(r_moves) >= DEPTH_LIMIT) n_state = ST_NEXT;
                else if (has_split) n_state = ST_SPLIT_WAIT;
                else n_state = ST_DECIDE;
            end
            ST_SPLIT_WAIT: n_state = ST_FEAT_WAIT;
            ST_FEAT_WAIT:  n_state = ST_DECIDE;
            ST_DECIDE:     n_state = ST_NODE;
            ST_VOTE:       n_state = ST_NEXT;
            ST_NEXT:       n_state = (r_tree < r_ntrees) ? ST_ROOT : ST_DONE;
            ST_DONE:       n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // datapath
    logic [6:0] vote_now, vote_inc;
    assign vote_now = r_votes[nd_cls[CW-1:0]];
    assign vote_inc = (vote_now == 7'd127) ? vote_now : vote_now + 7'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tree_cfg <= 7'd1;
            r_class_cfg <= 4'd1;
            o_result_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_result_valid <= (r_state == ST_DONE);
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_TREE_COUNT:  r_tree_cfg <= i_cfg_data;
                    CFG_CLASS_COUNT: r_class_cfg <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
        unique case (r_state)
            ST_IDLE: begin
                r_clr <= '0;
                r_tree <= '0;
                r_best <= '0;
                r_pv <= '0;
                r_err <= 1'b0;
                r_ntrees <= (32'(r_tree_cfg) > TREE_COUNT) ? TCW'(TREE_COUNT)
                                                          : TCW'(r_tree_cfg);
                r_ncls <= (32'(r_class_cfg) > CLASS_COUNT) ? CCW'(CLASS_COUNT)
                                                          : CCW'(r_class_cfg);
            end
            ST_CLEAR: begin
                r_votes[r_clr] <= '0;
                r_clr <= r_clr + CW'(1);
            end
            ST_ROOT_WAIT: begin
                r_cur <= r_root_q;
                r_moves <= '0;
                r_tree <= r_tree + TCW'(1);
            end
            ST_NODE: if (!cur_ok) r_err <= 1'b1;
            ST_NODE_WAIT: if (!is_leaf && 32'(r_moves) >= DEPTH_LIMIT) r_err <= 1'b1;
            ST_DECIDE: begin
                r_moves <= r_moves + DW'(1);
                r_cur <= go_left ? nd_left : $signed({1'b0, nd_right});
            end
            ST_VOTE: if (cls_ok) begin
                r_votes[nd_cls[CW-1:0]] <= vote_inc;
                if (vote_inc > r_best) begin
                    r_best <= vote_inc;
                    r_pv <= nd_val;
                end
            end
            default: ;
        endcase
    end

    assign o_predicted_value = r_pv;
    assign o_winning_votes = r_best;
    assign o_walk_error = r_err;

    `FMV_ASSERT_NEXT(a_done_strobe, i_clk, i_rst_n, r_state == ST_DONE, o_result_valid)
    `FMV_ASSERT_IMP(a_result_idle, i_clk, i_rst_n, o_result_valid, !o_busy)
    `FMV_ASSERT_IMP(a_depth_bound, i_clk, i_rst_n, r_state == ST_DECIDE,
                    32'(r_moves) < DEPTH_LIMIT)
endmodule
